[rtl/mcpg_pkg.sv]
// shared types and constants of the midpoint circle point generator
package mcpg_pkg;

  localparam int COORD_BITS  = 11;
  localparam int RADIUS_BITS = 10;
  localparam int OFFY_BITS   = RADIUS_BITS + 1;
  localparam int DEC_BITS    = 14;
  localparam int OUT_BITS    = 13;
  localparam int NUM_OCT     = 8;
  localparam int OCT_BITS    = 3;
  localparam int ADDR_BITS   = 2;

  localparam logic                 FUNC_START   = 1'b0;
  localparam logic                 FUNC_STEP    = 1'b1;
  localparam logic [ADDR_BITS-1:0] ADDR_OCTMASK = 2'd0;
  localparam logic [7:0]           OCTMASK_RST  = 8'hff;

  // one iteration handed from the front to the back
  typedef struct packed {
    logic [COORD_BITS-1:0]       cx;
    logic [COORD_BITS-1:0]       cy;
    logic [COORD_BITS-1:0]       x;
    logic signed [OFFY_BITS-1:0] y;
    logic                        done;
  } job_t;

endpackage

[rtl/mcpg_fifo.sv]
// small register queue between the iteration front and the point back end
module mcpg_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + AW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + AW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

[rtl/mcpg_front.sv]
// front end: takes start and step beats, runs the midpoint update, queues iterations
module mcpg_front import mcpg_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic                   func_i,
  input  logic [COORD_BITS-1:0]  center_x_i,
  input  logic [COORD_BITS-1:0]  center_y_i,
  input  logic [RADIUS_BITS-1:0] radius_i,
  input  logic [NUM_OCT-1:0]     octant_mask_i,
  input  logic                   q_full_i,
  output logic                   q_push_o,
  output job_t                   q_job_o
);

  logic [COORD_BITS-1:0]       ox_q, ox_d;
  logic signed [OFFY_BITS-1:0] oy_q, oy_d;
  logic signed [DEC_BITS-1:0]  dec_q, dec_d;
  logic [COORD_BITS-1:0]       cx_q, cx_d, cy_q, cy_d;
  logic                        active_q, active_d;

  logic                        accept, emits, done;
  logic signed [DEC_BITS-1:0]  x_ext, y_ext;
  logic [COORD_BITS-1:0]       x_nx;
  logic signed [OFFY_BITS-1:0] y_nx;
  logic signed [DEC_BITS-1:0]  d_nx;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  assign x_ext = $signed({(DEC_BITS - COORD_BITS)'(0), ox_q});
  assign y_ext = {{(DEC_BITS - OFFY_BITS){oy_q[OFFY_BITS-1]}}, oy_q};

  always_comb begin
    if (dec_q <= 0) begin
      d_nx = dec_q + (x_ext <<< 2) + DEC_BITS'(6);
      y_nx = oy_q;
    end else begin
      d_nx = dec_q + ((x_ext - y_ext) <<< 2) + DEC_BITS'(10);
      y_nx = oy_q - OFFY_BITS'(1);
    end
    x_nx = ox_q + COORD_BITS'(1);
  end

  always_comb begin
    ox_d     = ox_q;
    oy_d     = oy_q;
    dec_d    = dec_q;
    cx_d     = cx_q;
    cy_d     = cy_q;
    active_d = active_q;
    emits    = 1'b0;
    done     = 1'b0;
    if (accept) begin
      if (func_i == FUNC_START) begin
        cx_d     = center_x_i;
        cy_d     = center_y_i;
        ox_d     = '0;
        oy_d     = $signed({1'b0, radius_i});
        dec_d    = DEC_BITS'(3)
                   - $signed({(DEC_BITS - RADIUS_BITS - 1)'(0), radius_i, 1'b0});
        active_d = 1'b1;
        emits    = 1'b1;
      end else if (active_q) begin
        ox_d  = x_nx;
        oy_d  = y_nx;
        dec_d = d_nx;
        done  = $signed({1'b0, x_nx}) > $signed({y_nx[OFFY_BITS-1], y_nx});
        if (done) begin
          active_d = 1'b0;
        end
        emits = 1'b1;
      end
    end
  end

  // the queued job carries the state after this beat
  assign q_push_o     = emits && (octant_mask_i != '0);
  assign q_job_o.cx   = cx_d;
  assign q_job_o.cy   = cy_d;
  assign q_job_o.x    = ox_d;
  assign q_job_o.y    = oy_d;
  assign q_job_o.done = done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ox_q     <= '0;
      oy_q     <= '0;
      dec_q    <= '0;
      cx_q     <= '0;
      cy_q     <= '0;
      active_q <= 1'b0;
    end else begin
      ox_q     <= ox_d;
      oy_q     <= oy_d;
      dec_q    <= dec_d;
      cx_q     <= cx_d;
      cy_q     <= cy_d;
      active_q <= active_d;
    end
  end

endmodule

[rtl/mcpg_back.sv]
// back end: walks the enabled symmetric points of one iteration, one beat a cycle unless stalled
module mcpg_back import mcpg_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       q_valid_i,
  input  job_t                       q_job_i,
  output logic                       q_pop_o,
  input  logic [NUM_OCT-1:0]         octant_mask_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic signed [OUT_BITS-1:0] point_x_o,
  output logic signed [OUT_BITS-1:0] point_y_o,
  output logic [OCT_BITS-1:0]        octant_o,
  output logic                       last_o,
  output logic                       done_o
);

  job_t                       job_q, job_d;
  logic [NUM_OCT-1:0]         rem_q, rem_d;
  logic                       busy_q, busy_d;
  logic                       valid_q, valid_d;
  logic signed [OUT_BITS-1:0] px_q, px_d, py_q, py_d;
  logic [OCT_BITS-1:0]        oct_q;
  logic                       last_q, done_q;

  logic                       out_free, emit, finishing, load;
  logic [OCT_BITS-1:0]        sel;
  logic [NUM_OCT-1:0]         sel_bit, rem_left;
  logic signed [OUT_BITS-1:0] cx, cy, xo, yo;

  assign out_free = !valid_q || out_ready_i;
  assign emit     = busy_q && out_free;

  // lowest enabled point still to go
  always_comb begin
    sel = '0;
    for (int i = NUM_OCT - 1; i >= 0; i--) begin
      if (rem_q[i]) begin
        sel = OCT_BITS'(i);
      end
    end
  end

  assign sel_bit   = NUM_OCT'(1) << sel;
  assign rem_left  = rem_q & ~sel_bit;
  assign finishing = emit && (rem_left == '0);
  assign load      = q_valid_i && (!busy_q || finishing);
  assign q_pop_o   = load;

  assign cx = $signed({(OUT_BITS - COORD_BITS)'(0), job_q.cx});
  assign cy = $signed({(OUT_BITS - COORD_BITS)'(0), job_q.cy});
  assign xo = $signed({(OUT_BITS - COORD_BITS)'(0), job_q.x});
  assign yo = {{(OUT_BITS - OFFY_BITS){job_q.y[OFFY_BITS-1]}}, job_q.y};

  always_comb begin
    case (sel)
      3'd0: begin px_d = cx + xo; py_d = cy + yo; end
      3'd1: begin px_d = cx - xo; py_d = cy + yo; end
      3'd2: begin px_d = cx + xo; py_d = cy - yo; end
      3'd3: begin px_d = cx - xo; py_d = cy - yo; end
      3'd4: begin px_d = cx + yo; py_d = cy + xo; end
      3'd5: begin px_d = cx - yo; py_d = cy + xo; end
      3'd6: begin px_d = cx + yo; py_d = cy - xo; end
      3'd7: begin px_d = cx - yo; py_d = cy - xo; end
      default: begin px_d = cx; py_d = cy; end
    endcase
  end

  always_comb begin
    job_d  = job_q;
    rem_d  = rem_q;
    busy_d = busy_q;
    if (load) begin
      job_d  = q_job_i;
      rem_d  = octant_mask_i;
      busy_d = (octant_mask_i != '0);
    end else if (emit) begin
      rem_d  = rem_left;
      busy_d = (rem_left != '0);
    end
    if (emit) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end else begin
      valid_d = valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      valid_q <= 1'b0;
      rem_q   <= '0;
    end else begin
      busy_q  <= busy_d;
      valid_q <= valid_d;
      rem_q   <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
    if (emit) begin
      px_q   <= px_d;
      py_q   <= py_d;
      oct_q  <= sel;
      last_q <= (rem_left == '0);
      done_q <= job_q.done;
    end
  end

  assign out_valid_o = valid_q;
  assign point_x_o   = px_q;
  assign point_y_o   = py_q;
  assign octant_o    = oct_q;
  assign last_o      = last_q;
  assign done_o      = done_q;

endmodule

[rtl/midpoint_circle_point_generator_top.sv]
// Midpoint circle point generator, top level.
// Input stream: a start beat (tuser = 0) loads center and radius and emits the
// eight symmetric points of x = 0, y = radius; a step beat (tuser = 1) runs one
// midpoint update and emits the points of the new position. A step with no
// circle in progress is taken and gives nothing.
// Output stream: one point per beat, filtered by the octant mask register;
// tlast marks the last point of an input beat, tuser[3] the final iteration.
// Path of a beat: job queue, back end job register, output register.
// Throughput: the back end sends one point per cycle while the receiver is
// ready, one per set mask bit (8 with the full mask); the front end takes a
// beat every cycle while the FIFO_DEPTH job queue has room.
// Stall: when the receiver holds tready low the output register keeps its
// beat, the back end stops and the queue fills, then s_axis_tready drops.
// Reset: no circle in progress, queue and output empty, mask all ones.
// APB: register octant_mask at address 0; write only while the block is idle.
module midpoint_circle_point_generator_top import mcpg_pkg::*; #(
  parameter int FIFO_DEPTH = 2
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [31:0]          s_axis_tdata,  // center_x, center_y, circle_radius
  input  logic [0:0]           s_axis_tuser,  // func
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [31:0]          m_axis_tdata,  // point_x, point_y, zero pad
  output logic [3:0]           m_axis_tuser,  // octant_index, circle_done
  output logic                 m_axis_tlast,  // last_of_run
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_BITS-1:0] paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  localparam int JOB_BITS = $bits(job_t);

  logic [NUM_OCT-1:0]         mask_q, mask_d;
  logic                       q_full, q_push, q_pop, q_valid;
  job_t                       push_job, head_job;
  logic [JOB_BITS-1:0]        head_bits;
  logic signed [OUT_BITS-1:0] pt_x, pt_y;
  logic [OCT_BITS-1:0]        oct;
  logic                       last, done;

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_OCTMASK) ? {24'd0, mask_q} : 32'd0;

  always_comb begin
    mask_d = mask_q;
    if (psel && penable && pwrite && pready && (paddr == ADDR_OCTMASK)) begin
      mask_d = pwdata[NUM_OCT-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= OCTMASK_RST;
    end else begin
      mask_q <= mask_d;
    end
  end

  mcpg_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .func_i        (s_axis_tuser[0]),
    .center_x_i    (s_axis_tdata[10:0]),
    .center_y_i    (s_axis_tdata[21:11]),
    .radius_i      (s_axis_tdata[31:22]),
    .octant_mask_i (mask_q),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_job_o       (push_job)
  );

  mcpg_fifo #(
    .WIDTH (JOB_BITS),
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (push_job),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (head_bits)
  );

  assign head_job = head_bits;

  mcpg_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_job_i       (head_job),
    .q_pop_o       (q_pop),
    .octant_mask_i (mask_q),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .point_x_o     (pt_x),
    .point_y_o     (pt_y),
    .octant_o      (oct),
    .last_o        (last),
    .done_o        (done)
  );

  assign m_axis_tdata = {6'd0, pt_y, pt_x};
  assign m_axis_tuser = {done, oct};
  assign m_axis_tlast = last;

endmodule
